### rtl/core/median_then_ewma_filter_macros.svh
// ----------------------------------------------------------------------------
// median_then_ewma_filter assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_THEN_EWMA_FILTER_MACROS_SVH
`define MEDIAN_THEN_EWMA_FILTER_MACROS_SVH

// condition must hold at every edge out of reset
`define MTEF_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mtef_pkg.sv
// ----------------------------------------------------------------------------
// mtef_pkg
// Shared widths, constants and types of the median / moving-average filter.
// ----------------------------------------------------------------------------
package mtef_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int AVG_W       = 20;
	localparam int WEIGHT_W    = 16;
	localparam int FRAC_W      = 8;
	localparam int WINDOW_DEF  = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd9830;
	localparam logic [AVG_W-1:0]    AVG_MAX      = 20'hFFF00;
	localparam logic [AVG_W-1:0]    AVG_SAT      = 20'hFFFFF;

	// APB register map, word addressed
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 1'd0;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SORT,
		B_PICK,
		B_MUL,
		B_ACC,
		B_OUT
	} back_state_t;

endpackage

### rtl/core/mtef_sample_if.sv
// ----------------------------------------------------------------------------
// mtef_sample_if
// Input channel: one ADC sample per beat.
// ----------------------------------------------------------------------------
interface mtef_sample_if;
	import mtef_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_code;

	modport source (output valid, output sample_code, input ready);
	modport sink   (input valid, input sample_code, output ready);
endinterface

### rtl/core/mtef_result_if.sv
// ----------------------------------------------------------------------------
// mtef_result_if
// Output channel: median and smoothed value per beat.
// ----------------------------------------------------------------------------
interface mtef_result_if;
	import mtef_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] median_value;
	logic [AVG_W-1:0]    smoothed_value;

	modport source (output valid, output median_value, output smoothed_value, input ready);
	modport sink   (input valid, input median_value, input smoothed_value, output ready);
endinterface

### rtl/core/median_then_ewma_filter.sv
// Each sample beat pushes a window snapshot into the queue. The back end pops it,
// sorts it by odd-even transposition, one pass per cycle, then runs pick, multiply
// and accumulate steps; it pops the next snapshot only once the result is taken.
// A two-entry snapshot queue lets samples arrive while a result waits.
// Reset clears the ring pointer, fill count, average and its primed flag, and sets
// the weight to 9830; window contents are not cleared.
`include "median_then_ewma_filter_macros.svh"

// ----------------------------------------------------------------------------
// median_then_ewma_filter
// Running median over a ring window followed by an exponential moving average.
// ----------------------------------------------------------------------------
module median_then_ewma_filter #(
	parameter int WINDOW = mtef_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mtef_sample_if.sink                         samples,
	mtef_result_if.source                       results,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mtef_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [mtef_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mtef_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import mtef_pkg::*;

	localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int ENTRY_W = WINDOW * SAMPLE_W + CNT_W;

	qstat_t                          qstat;
	logic                            push;
	logic                            pop;
	logic [WINDOW-1:0][SAMPLE_W-1:0] snap_win;
	logic [CNT_W-1:0]                snap_cnt;
	logic [ENTRY_W-1:0]              q_rdata;
	logic [WINDOW-1:0][SAMPLE_W-1:0] q_win;
	logic [CNT_W-1:0]                q_cnt;
	logic [WEIGHT_W-1:0]             weight_q;
	logic                            reg_hit;
	logic                            cfg_wr;

	// register file
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SMOOTHING_WEIGHT);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? APB_DATA_W'(weight_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_wr) begin
			weight_q <= pwdata[WEIGHT_W-1:0];
		end
	end

	mtef_front #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W),
		.CNT_W  (CNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.qstat    (qstat),
		.push     (push),
		.snap_win (snap_win),
		.snap_cnt (snap_cnt)
	);

	mtef_queue #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({snap_win, snap_cnt}),
		.pop    (pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	assign q_win = q_rdata[ENTRY_W-1:CNT_W];
	assign q_cnt = q_rdata[CNT_W-1:0];

	mtef_back #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W),
		.CNT_W  (CNT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.q_win   (q_win),
		.q_cnt   (q_cnt),
		.pop     (pop),
		.weight  (weight_q),
		.results (results)
	);

	`MTEF_ASSERT_NOW(a_queue_status, !(qstat.full && qstat.empty), "queue full and empty")
	`MTEF_ASSERT_NOW(a_avg_range, !results.valid || (results.smoothed_value <= AVG_MAX), "average out of range")
	`MTEF_ASSERT_NEXT(a_weight_wr, cfg_wr, weight_q == $past(pwdata[WEIGHT_W-1:0]), "weight write lost")

endmodule

### rtl/core/mtef_front.sv
// ----------------------------------------------------------------------------
// mtef_front
// Takes samples, keeps the ring window and pushes a padded window snapshot.
// ----------------------------------------------------------------------------
module mtef_front #(
	parameter int WINDOW = mtef_pkg::WINDOW_DEF,
	parameter int IDX_W  = 3,
	parameter int CNT_W  = 3
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	mtef_sample_if.sink                              samples,
	input  mtef_pkg::qstat_t                         qstat,
	output logic                                     push,
	output logic [WINDOW-1:0][mtef_pkg::SAMPLE_W-1:0] snap_win,
	output logic [CNT_W-1:0]                         snap_cnt
);
	import mtef_pkg::*;

	logic [WINDOW-1:0][SAMPLE_W-1:0] win_q;
	logic [IDX_W-1:0]                slot_q;
	logic [CNT_W-1:0]                fill_q;
	logic [CNT_W-1:0]                fill_d;
	logic [SAMPLE_W-1:0]             cur;

	assign samples.ready = !qstat.full;
	assign push          = samples.valid && !qstat.full;
	assign fill_d        = (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + 1'b1;
	assign snap_cnt      = fill_d;

	// unwritten slots are padded high so they sort to the top
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			cur         = (slot_q == IDX_W'(i)) ? samples.sample_code : win_q[i];
			snap_win[i] = (CNT_W'(i) < fill_d) ? cur : '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			win_q[slot_q] <= samples.sample_code;
		end
	end

endmodule

### rtl/core/mtef_queue.sv
// ----------------------------------------------------------------------------
// mtef_queue
// Small FIFO of window snapshots between front and back.
// ----------------------------------------------------------------------------
module mtef_queue #(
	parameter int DATA_W = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output mtef_pkg::qstat_t  qstat
);
	import mtef_pkg::*;

	logic [DATA_W-1:0] mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rdata       = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

endmodule

### rtl/core/mtef_back.sv
// ----------------------------------------------------------------------------
// mtef_back
// Sorts a snapshot by odd-even transposition, picks the median and
// updates the moving average.
// ----------------------------------------------------------------------------
module mtef_back #(
	parameter int WINDOW = mtef_pkg::WINDOW_DEF,
	parameter int IDX_W  = 3,
	parameter int CNT_W  = 3
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mtef_pkg::qstat_t                         qstat,
	input  logic [WINDOW-1:0][mtef_pkg::SAMPLE_W-1:0] q_win,
	input  logic [CNT_W-1:0]                         q_cnt,
	output logic                                     pop,
	input  logic [mtef_pkg::WEIGHT_W-1:0]            weight,
	mtef_result_if.source                            results
);
	import mtef_pkg::*;

	localparam int PROD_W = AVG_W + 1 + WEIGHT_W + 1;

	back_state_t state_q, state_d;

	logic [WINDOW-1:0][SAMPLE_W-1:0] vals_q;
	logic [WINDOW-1:0][SAMPLE_W-1:0] vals_d;
	logic [CNT_W-1:0]                cnt_q;
	logic [IDX_W-1:0]                pass_q;
	logic [CNT_W-1:0]                mid;
	logic [SAMPLE_W-1:0]             med_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic signed [PROD_W-1:0]        prod_shr;
	logic [AVG_W-1:0]                avg_q;
	logic                            primed_q;
	logic [AVG_W-1:0]                target;
	logic signed [AVG_W:0]           diff;
	logic signed [AVG_W+1:0]         step;
	logic signed [AVG_W+1:0]         sum;
	logic [AVG_W-1:0]                avg_next;

	// one transposition pass: pairs starting at the pass parity
	always_comb begin
		vals_d = vals_q;
		for (int i = 0; i + 1 < WINDOW; i++) begin
			if ((i % 2) == int'(pass_q[0]) && (vals_q[i+1] < vals_q[i])) begin
				vals_d[i]   = vals_q[i+1];
				vals_d[i+1] = vals_q[i];
			end
		end
	end

	assign mid      = cnt_q >> 1;
	assign target   = {med_q, {FRAC_W{1'b0}}};
	assign diff     = $signed({1'b0, target}) - $signed({1'b0, avg_q});
	assign prod_shr = prod_q >>> WEIGHT_W;
	assign step     = $signed(prod_shr[AVG_W+1:0]);
	assign sum      = $signed({2'b00, avg_q}) + step;

	always_comb begin
		if (sum < 0) begin
			avg_next = '0;
		end else if (sum > $signed({2'b00, AVG_SAT})) begin
			avg_next = AVG_SAT;
		end else begin
			avg_next = sum[AVG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		results.valid = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = B_SORT;
				end
			end
			B_SORT: begin
				if (pass_q == IDX_W'(WINDOW - 1)) begin
					state_d = B_PICK;
				end
			end
			B_PICK: state_d = B_MUL;
			B_MUL:  state_d = B_ACC;
			B_ACC:  state_d = B_OUT;
			B_OUT: begin
				results.valid = 1'b1;
				if (results.ready) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q   <= '0;
			avg_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			if (pop) begin
				pass_q <= '0;
			end else if (state_q == B_SORT) begin
				pass_q <= pass_q + 1'b1;
			end
			if (state_q == B_ACC) begin
				avg_q    <= primed_q ? avg_next : target;
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			vals_q <= q_win;
			cnt_q  <= q_cnt;
		end else if (state_q == B_SORT) begin
			vals_q <= vals_d;
		end
		if (state_q == B_PICK) begin
			med_q <= vals_q[mid[IDX_W-1:0]];
		end
		if (state_q == B_MUL) begin
			prod_q <= diff * $signed({1'b0, weight});
		end
	end

	assign results.median_value   = med_q;
	assign results.smoothed_value = avg_q;

endmodule

### test/tb_median_then_ewma_filter.sv
// ----------------------------------------------------------------------------
// tb_median_then_ewma_filter
// Drives ADC samples through the running-median / moving-average filter and
// checks every result beat against an in-bench model of the window, the
// median pick and the Q12.8 average. The smoothing weight is changed over APB
// between phases and read back. Traffic runs with and without random gaps on
// the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_median_then_ewma_filter;
	import mtef_pkg::*;

	localparam int WINDOW_LEN  = WINDOW_DEF;
	localparam int SETTLE      = 2 * (WINDOW_LEN + 5) + 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BEATS = 188;
	localparam int MAX_PRINTS  = 40;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'd1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] median;
		logic [AVG_W-1:0]    smoothed;
	} filter_out_t;

	class filter_scoreboard;
		logic [SAMPLE_W-1:0] ring [WINDOW_LEN];
		int unsigned         slot;
		int unsigned         filled;
		logic [AVG_W-1:0]    avg;
		bit                  primed;
		logic [WEIGHT_W-1:0] weight;
		filter_out_t         expected_q [$];
		int unsigned         errors;
		int unsigned         noted;
		int unsigned         checked;

		function new();
			slot = 0;
			filled = 0;
			avg = '0;
			primed = 0;
			weight = WEIGHT_RESET;
			errors = 0;
			noted = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
			if (idx == REG_SMOOTHING_WEIGHT) begin
				weight = value[WEIGHT_W-1:0];
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] code);
			logic [SAMPLE_W-1:0] sorted [WINDOW_LEN];
			logic [SAMPLE_W-1:0] t;
			logic [AVG_W-1:0]    target;
			longint              diff;
			longint              nxt;
			filter_out_t         res;
			ring[slot] = code;
			slot = (slot + 1) % WINDOW_LEN;
			if (filled < WINDOW_LEN) begin
				filled++;
			end
			// only the entries written so far take part
			for (int i = 0; i < filled; i++) begin
				sorted[i] = ring[i];
			end
			for (int i = 0; i + 1 < filled; i++) begin
				for (int j = i + 1; j < filled; j++) begin
					if (sorted[j] < sorted[i]) begin
						t = sorted[i];
						sorted[i] = sorted[j];
						sorted[j] = t;
					end
				end
			end
			res.median = sorted[filled / 2];
			target = {res.median, {FRAC_W{1'b0}}};
			if (!primed) begin
				avg = target;
				primed = 1;
			end else begin
				diff = longint'(target) - longint'(avg);
				// arithmetic shift of a signed product floors toward minus infinity
				nxt = longint'(avg) + ((diff * longint'(weight)) >>> 16);
				if (nxt < 0) begin
					nxt = 0;
				end
				if (nxt > longint'(AVG_SAT)) begin
					nxt = longint'(AVG_SAT);
				end
				avg = nxt[AVG_W-1:0];
			end
			res.smoothed = avg;
			expected_q.push_back(res);
			noted++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endtask

		task check_result(logic [SAMPLE_W-1:0] median, logic [AVG_W-1:0] smoothed);
			filter_out_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat median=%0d avg=%h with nothing expected",
					median, smoothed));
			end else begin
				exp_res = expected_q.pop_front();
				checked++;
				if (median !== exp_res.median) begin
					report($sformatf("beat %0d median_value %0d, expected %0d",
						checked, median, exp_res.median));
				end
				if (smoothed !== exp_res.smoothed) begin
					report($sformatf("beat %0d smoothed_value %h, expected %h",
						checked, smoothed, exp_res.smoothed));
				end
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mtef_sample_if sample_ch ();
	mtef_result_if result_ch ();

	median_then_ewma_filter #(
		.WINDOW(WINDOW_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	filter_scoreboard    sb;
	int unsigned         sender_idle_pct;
	int unsigned         receiver_stall_pct;
	int unsigned         weight_settings;
	logic [SAMPLE_W-1:0] level;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("run timed out after %0d cycles", CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// result side: ready changes on the falling edge, beats taken on the rising edge
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.median_value, result_ch.smoothed_value);
			end
		end
	end

	task apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task set_weight(input logic [WEIGHT_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		apb_write(REG_SMOOTHING_WEIGHT, {{(APB_DATA_W-WEIGHT_W){1'b0}}, value});
		apb_read(REG_SMOOTHING_WEIGHT, rd);
		if (rd !== {{(APB_DATA_W-WEIGHT_W){1'b0}}, sb.weight}) begin
			sb.report($sformatf("weight read back %h, expected %h", rd, sb.weight));
		end
		weight_settings++;
	endtask

	// entered just after a rising edge; leaves valid high after its beat
	task send_sample(input logic [SAMPLE_W-1:0] code);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.sample_code <= code;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(code);
	endtask

	task drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// half the time a rarely changing level (ties) with or without noise, else outliers and bit patterns
	function logic [SAMPLE_W-1:0] next_sample();
		int v;
		int unsigned pick;
		pick = $urandom_range(9);
		if ($urandom_range(19) == 0) begin
			level = SAMPLE_W'($urandom);
		end
		case (pick)
			0, 1, 2, 3: begin
				v = int'(level) + int'($urandom_range(30)) - 15;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				return v[SAMPLE_W-1:0];
			end
			6: return $urandom_range(1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
			7: return level;
			8: begin
				v = 1 << $urandom_range(SAMPLE_W - 1);
				return $urandom_range(1) ? ~v[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [APB_DATA_W-1:0] rd;
		sb = new();
		weight_settings = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		level = 12'd2000;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_code = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(negedge clk);

		// write to an unmapped index must leave the weight at its reset value
		apb_write(REG_UNMAPPED, 32'h0000_1234);
		apb_read(REG_SMOOTHING_WEIGHT, rd);
		if (rd !== {{(APB_DATA_W-WEIGHT_W){1'b0}}, WEIGHT_RESET}) begin
			sb.report($sformatf("weight after reset / unmapped write %h", rd));
		end

		// reset weight: first beat loads the average, window fills up
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd0);
		drain();

		// zero weight: average holds
		set_weight(16'd0);
		send_sample(12'd100);
		send_sample(12'd4000);
		send_sample(12'd3000);
		send_sample(12'd7);
		send_sample(12'd4095);
		drain();

		// full weight: largest steps both ways
		set_weight(16'hFFFF);
		repeat (3) send_sample(12'd0);
		repeat (4) send_sample(12'd4095);
		drain();

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					set_weight(WEIGHT_W'($urandom_range(65535)));
				end
				1: begin
					sender_idle_pct = 62;
					receiver_stall_pct = 0;
					set_weight(WEIGHT_W'($urandom_range(65535, 50000)));
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 62;
					set_weight(16'd1);
				end
				default: begin
					sender_idle_pct = 31;
					receiver_stall_pct = 31;
					set_weight(WEIGHT_W'($urandom_range(65535)));
				end
			endcase
			repeat (PHASE_BEATS) send_sample(next_sample());
			drain();
		end

		$display("%0d sample beats sent, %0d result beats checked, %0d weight settings",
			sb.noted, sb.checked, weight_settings);
		$display("traffic mixes: steady, sender gaps, result stalls, both; %0d mismatches",
			sb.errors);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mtef_pkg.sv
rtl/core/mtef_sample_if.sv
rtl/core/mtef_result_if.sv
rtl/core/mtef_front.sv
rtl/core/mtef_queue.sv
rtl/core/mtef_back.sv
rtl/core/median_then_ewma_filter.sv
test/tb_median_then_ewma_filter.sv
